// ===== rtl/number_to_ascii_formatter_top_defines.svh =====
// assertion macros for the formatter
`ifndef NUMBER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH
`define NUMBER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH

// same-cycle implication on the block clock
`define NTA_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("nta assertion failed");

// next-cycle implication on the block clock
`define NTA_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("nta assertion failed");

`endif

// ===== rtl/nta_pkg.sv =====
`default_nettype none

package nta_pkg;

  localparam int MAX_FIELD      = 63;
  localparam int NUM_DIGITS     = 20;
  localparam int DIG_IDX_W      = $clog2(NUM_DIGITS);
  localparam int VALUE_W        = 64;
  localparam int BITS_PER_CYCLE = 4;
  localparam int CONV_CYCLES    = VALUE_W / BITS_PER_CYCLE;
  localparam int CONV_CNT_W     = $clog2(CONV_CYCLES);
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_LHEX = 3'd2;
  localparam logic [2:0] OP_UHEX = 3'd3;
  localparam logic [2:0] OP_CHAR = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] value;
    logic [5:0]  width;
    logic [5:0]  precision;
    logic        force_sign;
    logic        pad_before;
    logic        zero_pad;
  } nta_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } nta_out_t;

  typedef struct packed {
    logic                           is_char;
    logic [7:0]                     chr;
    logic [NUM_DIGITS-1:0][3:0]     digits;
    logic [4:0]                     ndig;
    logic                           has_sign;
    logic [7:0]                     sign_ch;
    logic                           upper;
    logic [4:0]                     text_len;
    logic [5:0]                     pad_len;
    logic [5:0]                     last_idx;
    logic                           pad_first;
    logic [7:0]                     pad_ch;
  } nta_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } nta_qstat_t;

  function automatic logic [7:0] nib_char(input logic [3:0] n, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UP_A : CH_LOW_A;
    if (n < 4'd10) begin
      return CH_ZERO + {4'b0, n};
    end
    return base + {4'b0, n} - 8'd10;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nta_front.sv =====
`default_nettype none

module nta_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire nta_pkg::nta_in_t  in_data,
  input  wire nta_pkg::nta_qstat_t q_stat,
  output logic                   q_push,
  output nta_pkg::nta_job_t      q_data
);

  localparam int DW = nta_pkg::NUM_DIGITS * 4;
  localparam int VW = nta_pkg::VALUE_W;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_CONV = 4'b0010,
    F_SIZE = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t                    state_r, state_nxt;
  logic [DW+VW-1:0]                work_r, work_nxt;
  logic [nta_pkg::CONV_CNT_W-1:0]  step_r, step_nxt;
  logic                            is_char_r, neg_r, plus_r, upper_r, before_r, zero_r;
  logic [7:0]                      chr_r;
  logic [5:0]                      width_r, prec_r;
  nta_pkg::nta_job_t               job_r, job_nxt;

  logic                            accept;
  logic                            op_ok;
  logic                            op_dec;
  logic                            op_hex;
  logic                            in_neg;
  logic [VW-1:0]                   mag;
  logic [DW+VW-1:0]                conv_w;
  logic [4:0]                      ndig;
  logic                            sign_on;
  logic [4:0]                      len;
  logic [4:0]                      text;
  logic [5:0]                      wid;
  logic [5:0]                      pad;
  logic [5:0]                      total;

  function automatic logic [DW+VW-1:0] dd_step(input logic [DW+VW-1:0] w);
    logic [DW+VW-1:0] t;
    t = w;
    for (int j = 0; j < nta_pkg::NUM_DIGITS; j++) begin
      if (t[VW+4*j +: 4] >= 4'd5) begin
        t[VW+4*j +: 4] = t[VW+4*j +: 4] + 4'd3;
      end
    end
    return {t[DW+VW-2:0], 1'b0};
  endfunction

  assign in_full = (state_r != F_IDLE);
  assign accept  = in_push && (state_r == F_IDLE);
  assign op_ok   = (in_data.opcode <= nta_pkg::OP_CHAR);
  assign op_dec  = (in_data.opcode == nta_pkg::OP_SDEC) || (in_data.opcode == nta_pkg::OP_UDEC);
  assign op_hex  = (in_data.opcode == nta_pkg::OP_LHEX) || (in_data.opcode == nta_pkg::OP_UHEX);
  assign in_neg  = (in_data.opcode == nta_pkg::OP_SDEC) && in_data.value[63];
  assign mag     = in_neg ? (64'd0 - in_data.value) : in_data.value;
  assign q_push  = (state_r == F_PUSH) && !q_stat.full;
  assign q_data  = job_r;

  always_comb begin
    conv_w = work_r;
    for (int s = 0; s < nta_pkg::BITS_PER_CYCLE; s++) begin
      conv_w = dd_step(conv_w);
    end
  end

  // digit count, sign and field sizing
  always_comb begin
    ndig = 5'd1;
    for (int j = 0; j < nta_pkg::NUM_DIGITS; j++) begin
      if (work_r[VW+4*j +: 4] != 4'd0) begin
        ndig = 5'(j + 1);
      end
    end
    sign_on = !is_char_r && (neg_r || plus_r);
    len     = is_char_r ? 5'd1 : (ndig + {4'b0, sign_on});
    text    = ({1'b0, len} < prec_r) ? len : prec_r[4:0];
    wid     = (int'(width_r) > nta_pkg::MAX_FIELD) ? 6'(nta_pkg::MAX_FIELD) : width_r;
    pad     = (wid > {1'b0, text}) ? (wid - {1'b0, text}) : 6'd0;
    total   = {1'b0, text} + pad;
  end

  always_comb begin
    state_nxt = state_r;
    work_nxt  = work_r;
    step_nxt  = step_r;
    job_nxt   = job_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          step_nxt = '0;
          if (op_hex) begin
            work_nxt = {{(DW-VW){1'b0}}, mag, {VW{1'b0}}};
          end else begin
            work_nxt = {{DW{1'b0}}, mag};
          end
          if (!op_ok) begin
            state_nxt = F_IDLE;
          end else if (op_dec) begin
            state_nxt = F_CONV;
          end else begin
            state_nxt = F_SIZE;
          end
        end
      end
      F_CONV: begin
        work_nxt = conv_w;
        step_nxt = step_r + 1'b1;
        if (step_r == nta_pkg::CONV_CNT_W'(nta_pkg::CONV_CYCLES - 1)) begin
          state_nxt = F_SIZE;
        end
      end
      F_SIZE: begin
        job_nxt.is_char   = is_char_r;
        job_nxt.chr       = chr_r;
        job_nxt.digits    = work_r[DW+VW-1:VW];
        job_nxt.ndig      = ndig;
        job_nxt.has_sign  = sign_on;
        job_nxt.sign_ch   = neg_r ? nta_pkg::CH_MINUS : nta_pkg::CH_PLUS;
        job_nxt.upper     = upper_r;
        job_nxt.text_len  = text;
        job_nxt.pad_len   = pad;
        job_nxt.last_idx  = total - 6'd1;
        job_nxt.pad_first = before_r;
        job_nxt.pad_ch    = zero_r ? nta_pkg::CH_ZERO : nta_pkg::CH_SPACE;
        state_nxt = (total == 6'd0) ? F_IDLE : F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    step_r <= step_nxt;
    job_r  <= job_nxt;
    if (accept) begin
      is_char_r <= (in_data.opcode == nta_pkg::OP_CHAR);
      neg_r     <= in_neg;
      plus_r    <= in_data.force_sign;
      upper_r   <= (in_data.opcode == nta_pkg::OP_UHEX);
      before_r  <= in_data.pad_before;
      zero_r    <= in_data.zero_pad;
      chr_r     <= in_data.value[7:0];
      width_r   <= in_data.width;
      prec_r    <= in_data.precision;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nta_queue.sv =====
`default_nettype none

module nta_queue #(
  parameter int DEPTH = nta_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire nta_pkg::nta_job_t   push_data,
  input  wire logic                pop,
  output nta_pkg::nta_job_t        head,
  output nta_pkg::nta_qstat_t      stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  nta_pkg::nta_job_t mem_r [DEPTH];
  logic [PW-1:0]     wptr_r, wptr_nxt;
  logic [PW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nta_back.sv =====
`default_nettype none

module nta_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire nta_pkg::nta_qstat_t q_stat,
  input  wire nta_pkg::nta_job_t   q_head,
  output logic                     q_pop,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output nta_pkg::nta_out_t        out_data
);

  logic                            out_valid_r;
  nta_pkg::nta_out_t               out_r;
  logic [5:0]                      k_r, k_nxt;
  logic                            produce;
  logic                            at_last;
  logic                            pad_zone;
  logic [5:0]                      ti_full;
  logic [4:0]                      ti;
  logic [nta_pkg::DIG_IDX_W-1:0]   di;
  logic [7:0]                      ch;

  assign produce   = !q_stat.empty && (!out_valid_r || out_pop);
  assign at_last   = (k_r == q_head.last_idx);
  assign q_pop     = produce && at_last;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign k_nxt     = at_last ? 6'd0 : k_r + 6'd1;

  // pick the character at position k of the field
  always_comb begin
    if (q_head.pad_first) begin
      pad_zone = (k_r < q_head.pad_len);
      ti_full  = k_r - q_head.pad_len;
    end else begin
      pad_zone = (k_r >= {1'b0, q_head.text_len});
      ti_full  = k_r;
    end
    ti = ti_full[4:0];
    di = nta_pkg::DIG_IDX_W'(q_head.ndig - 5'd1 - ti + {4'b0, q_head.has_sign});
    if (pad_zone) begin
      ch = q_head.pad_ch;
    end else if (q_head.is_char) begin
      ch = q_head.chr;
    end else if (q_head.has_sign && (ti == 5'd0)) begin
      ch = q_head.sign_ch;
    end else begin
      ch = nta_pkg::nib_char(q_head.digits[di], q_head.upper);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else if (produce) begin
      out_valid_r <= 1'b1;
      k_r         <= k_nxt;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_r.character <= ch;
      out_r.last      <= at_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/number_to_ascii_formatter_top.sv =====
// printf-style integer formatter
// input channel: drive in_data and raise in_push; the transaction is taken on a
// clock edge with in_push high and in_full low. in_full stays high while the
// front end works on a transaction, so one transaction is taken at a time.
// result channel: one character per transaction on out_data while out_empty is
// low; out_pop takes it. out_data.last marks the final character of a field.
// decimal opcodes run a shift-and-add-3 converter at 4 bits per cycle, then
// the sizing and push states put the job in the queue; hex and character
// opcodes skip the converter. a job's first character is registered once
// the job is at the queue head and the output register is free, then one
// character per cycle while out_pop stays high, up to 63 characters per field.
// the input side takes no new transaction until the front end is idle again;
// a push waits for queue room. opcodes 5 to 7 and empty fields give no output.
// a stalled receiver holds the current character; the queue then fills and
// the input side backs up through in_full.
// synchronous reset (rst_n low) empties the queue and drops any character in
// flight; no clearing pass is needed.
`default_nettype none

`include "number_to_ascii_formatter_top_defines.svh"

module number_to_ascii_formatter_top #(
  parameter int QDEPTH = nta_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire nta_pkg::nta_in_t  in_data,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output nta_pkg::nta_out_t      out_data
);

  nta_pkg::nta_qstat_t q_stat;
  nta_pkg::nta_job_t   q_job;
  nta_pkg::nta_job_t   q_head;
  logic                q_push;
  logic                q_pop;

  nta_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data  (q_job)
  );

  nta_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_job),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  nta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  `NTA_ASSERT_NOW(a_no_push_when_full, q_stat.full, !q_push)
  `NTA_ASSERT_NEXT(a_busy_after_accept, in_push && !in_full && (in_data.opcode <= nta_pkg::OP_CHAR), in_full)
  `NTA_ASSERT_NEXT(a_job_reaches_output, !q_stat.empty && (out_empty || out_pop), !out_empty)

endmodule

`default_nettype wire
